>>> src/cache_set_occupancy_tracker_assert.svh
// Assertion macros used by the occupancy tracker checker.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef CACHE_SET_OCCUPANCY_TRACKER_ASSERT_SVH
`define CACHE_SET_OCCUPANCY_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define CSOT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csot check failed");

// Next-cycle implication, disabled in reset
`define CSOT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csot check failed");

`endif

>>> src/csot_pkg.sv
// Shared types and constants of the cache set occupancy tracker.
// No dependencies.
package csot_pkg;

  localparam int SET_COUNT_DEF      = 2048;
  localparam int SLICE_COUNT_DEF    = 26;
  localparam int TABLE_SIZE_DEF     = 512;
  localparam int MASK_COUNT_DEF     = 6;
  localparam int BIN_COUNT_DEF      = 40;
  localparam int LINES_PER_PAGE_DEF = 64;

  localparam int CFG_MASKS     = 6;
  localparam int LINE_SHIFT    = 6;
  localparam int LINE_BYTES    = 64;
  localparam int QUEUE_DEPTH   = 2;
  localparam logic [7:0] WAY_LIMIT_RST = 8'd12;

  // configuration register indexes
  localparam logic [2:0] CFG_WAY_LIMIT = 3'd0;
  localparam logic [2:0] CFG_MASK_0    = 3'd1;
  localparam logic [2:0] CFG_MASK_1    = 3'd2;
  localparam logic [2:0] CFG_MASK_2    = 3'd3;
  localparam logic [2:0] CFG_MASK_3    = 3'd4;
  localparam logic [2:0] CFG_MASK_4    = 3'd5;
  localparam logic [2:0] CFG_MASK_5    = 3'd6;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_SNAP   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] page_address;
    logic [8:0]  table_index;
    logic [4:0]  table_slice;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  bin_index;
    logic [15:0] bin_count;
    logic [15:0] over_limit;
    logic        last;
  } out_item_t;

  // classified command held in the queue
  typedef struct packed {
    op_t         op;
    logic [63:0] page_address;
    logic [8:0]  table_index;
    logic [4:0]  table_slice;
  } cmd_t;

  // back end to front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_LINE  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_EMIT  = 6'b100000
  } back_state_t;

endpackage

>>> src/cache_set_occupancy_tracker.sv
// Top level of the cache set occupancy tracker: config registers, front, back.
// Depends on csot_pkg, csot_front, csot_back.
//
// After reset the block clears its SLICE_COUNT*SET_COUNT counter memory one
// entry per cycle and takes no input beat until done. A table load writes an
// in-range slice table entry when the back end pops it. A page add or remove
// is dispatched, steps through its LINES_PER_PAGE lines and then waits for
// the read-modify-write pipeline on the counter memory to drain; the memory's
// single read and write port sets the rate of one line per cycle. A snapshot
// is dispatched, reads every counter once, waits for the last read and then
// sends BIN_COUNT result beats, one per cycle while out_ready stays high, the
// last marked by last. A two-entry queue lets input beats be taken while the
// back end is busy.
module cache_set_occupancy_tracker #(
  parameter int SET_COUNT      = csot_pkg::SET_COUNT_DEF,
  parameter int SLICE_COUNT    = csot_pkg::SLICE_COUNT_DEF,
  parameter int TABLE_SIZE     = csot_pkg::TABLE_SIZE_DEF,
  parameter int MASK_COUNT     = csot_pkg::MASK_COUNT_DEF,
  parameter int BIN_COUNT      = csot_pkg::BIN_COUNT_DEF,
  parameter int LINES_PER_PAGE = csot_pkg::LINES_PER_PAGE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  csot_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output csot_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_wdata
);
  import csot_pkg::*;

  logic [7:0]  way_limit_r;
  logic [63:0] mask_r [CFG_MASKS];
  logic        q_valid;
  cmd_t        q_data;
  back_ctl_t   ctl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      way_limit_r <= WAY_LIMIT_RST;
      for (int j = 0; j < CFG_MASKS; j++) begin
        mask_r[j] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WAY_LIMIT: way_limit_r <= cfg_wdata[7:0];
        CFG_MASK_0:    mask_r[0]   <= cfg_wdata;
        CFG_MASK_1:    mask_r[1]   <= cfg_wdata;
        CFG_MASK_2:    mask_r[2]   <= cfg_wdata;
        CFG_MASK_3:    mask_r[3]   <= cfg_wdata;
        CFG_MASK_4:    mask_r[4]   <= cfg_wdata;
        CFG_MASK_5:    mask_r[5]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  csot_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .ctl      (ctl)
  );

  csot_back #(
    .SET_COUNT      (SET_COUNT),
    .SLICE_COUNT    (SLICE_COUNT),
    .TABLE_SIZE     (TABLE_SIZE),
    .MASK_COUNT     (MASK_COUNT),
    .BIN_COUNT      (BIN_COUNT),
    .LINES_PER_PAGE (LINES_PER_PAGE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .ctl       (ctl),
    .way_limit (way_limit_r),
    .perm_mask (mask_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule

>>> src/csot_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module csot_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

>>> src/csot_front.sv
// Front end: accepts input beats, classifies the operation, queues commands.
// Depends on csot_pkg.
module csot_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  csot_pkg::in_item_t  in_data,
  output logic                q_valid,
  output csot_pkg::cmd_t      q_data,
  input  csot_pkg::back_ctl_t ctl
);
  import csot_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          q_mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          push;
  cmd_t          cmd;

  assign in_ready = (cnt_r < (PW+1)'(QUEUE_DEPTH)) && !ctl.clearing;
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_data   = q_mem_r[rd_ptr_r];

  // classify the incoming beat
  always_comb begin
    cmd.page_address = in_data.page_address;
    cmd.table_index  = in_data.table_index;
    cmd.table_slice  = in_data.table_slice;
    case (in_data.operation)
      OP_LOAD:   cmd.op = OP_LOAD;
      OP_ADD:    cmd.op = OP_ADD;
      OP_REMOVE: cmd.op = OP_REMOVE;
      default:   cmd.op = OP_SNAP;
    endcase
  end

  // queue pointers
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (ctl.pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !ctl.pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && ctl.pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end
endmodule

>>> src/csot_back.sv
// Back end: clearing pass, per-line counter updates, snapshot scan and
// histogram readout. Depends on csot_pkg and csot_ram.
module csot_back #(
  parameter int SET_COUNT      = csot_pkg::SET_COUNT_DEF,
  parameter int SLICE_COUNT    = csot_pkg::SLICE_COUNT_DEF,
  parameter int TABLE_SIZE     = csot_pkg::TABLE_SIZE_DEF,
  parameter int MASK_COUNT     = csot_pkg::MASK_COUNT_DEF,
  parameter int BIN_COUNT      = csot_pkg::BIN_COUNT_DEF,
  parameter int LINES_PER_PAGE = csot_pkg::LINES_PER_PAGE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  csot_pkg::cmd_t      q_data,
  output csot_pkg::back_ctl_t ctl,
  input  logic [7:0]          way_limit,
  input  logic [63:0]         perm_mask [csot_pkg::CFG_MASKS],
  output logic                out_valid,
  input  logic                out_ready,
  output csot_pkg::out_item_t out_data
);
  import csot_pkg::*;

  localparam int SET_W     = $clog2(SET_COUNT);
  localparam int TAB_W     = $clog2(TABLE_SIZE);
  localparam int IDX_W     = (TAB_W > MASK_COUNT) ? TAB_W : MASK_COUNT;
  localparam int CNT_DEPTH = SLICE_COUNT * SET_COUNT;
  localparam int CNT_AW    = $clog2(CNT_DEPTH);
  localparam int BIN_W     = $clog2(BIN_COUNT);
  localparam int LC_W      = $clog2(LINES_PER_PAGE + 1);

  back_state_t       state_r, state_nxt;
  logic [63:0]       line_addr_r, line_addr_nxt;
  logic              add_r, add_nxt;
  logic [LC_W-1:0]   line_cnt_r, line_cnt_nxt;
  logic              p1_v_r, p1_v_nxt;
  logic [SET_W-1:0]  p1_set_r;
  logic              p1_beyond_r;
  logic              p2_v_r;
  logic [CNT_AW-1:0] p2_addr_r, p2_addr_nxt;
  logic [CNT_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [CNT_AW-1:0] scan_addr_r, scan_addr_nxt;
  logic              sc_v_r, sc_v_nxt;
  logic [15:0]       viol_r;
  logic [15:0]       hist_r [BIN_COUNT];
  logic [BIN_W-1:0]  emit_cnt_r, emit_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r;
  logic              emit_load, hist_clear;

  // stage 0 hashing
  logic [MASK_COUNT-1:0] perm;
  logic [IDX_W:0]        idx_full;
  logic                  beyond0;
  logic [SET_W-1:0]      set0;

  // memory ports
  logic              tbl_we;
  logic [TAB_W-1:0]  tbl_waddr, tbl_raddr;
  logic [4:0]        tbl_rdata;
  logic              cnt_we;
  logic [CNT_AW-1:0] cnt_waddr, cnt_raddr;
  logic [15:0]       cnt_wdata, cnt_rdata;
  logic [BIN_W-1:0]  bin_sel;
  logic [5:0]        slice_q;

  always_comb begin
    for (int j = 0; j < MASK_COUNT; j++) begin
      perm[j] = ^(line_addr_r & perm_mask[j]);
    end
    idx_full = (IDX_W+1)'(line_addr_r[LINE_SHIFT +: TAB_W]) ^ (IDX_W+1)'(perm);
    beyond0  = (idx_full >= (IDX_W+1)'(TABLE_SIZE));
    set0     = line_addr_r[LINE_SHIFT +: SET_W];
  end

  assign tbl_raddr = TAB_W'(idx_full);
  assign tbl_waddr = TAB_W'(q_data.table_index);

  // stage 1: slice lookup result gives the counter address
  always_comb begin
    if (p1_beyond_r || (32'(tbl_rdata) >= 32'(SLICE_COUNT))) begin
      slice_q = '0;
    end else begin
      slice_q = 6'(tbl_rdata);
    end
    p2_addr_nxt = (CNT_AW'(slice_q) << SET_W) | CNT_AW'(p1_set_r);
  end

  // stage 2 and clearing share the counter write port
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = p2_addr_r;
    cnt_wdata = cnt_rdata;
    if (state_r == ST_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_addr_r;
      cnt_wdata = '0;
    end else if (p2_v_r) begin
      cnt_we = 1'b1;
      if (add_r) begin
        cnt_wdata = (cnt_rdata == 16'hFFFF) ? cnt_rdata : cnt_rdata + 16'd1;
      end else begin
        cnt_wdata = (cnt_rdata == 16'd0) ? cnt_rdata : cnt_rdata - 16'd1;
      end
    end
  end

  assign cnt_raddr = (state_r == ST_SCAN) ? scan_addr_r : p2_addr_nxt;

  // histogram bin of the scanned counter
  assign bin_sel = (cnt_rdata >= 16'(BIN_COUNT-1)) ? BIN_W'(BIN_COUNT-1) : BIN_W'(cnt_rdata);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    line_addr_nxt = line_addr_r;
    add_nxt       = add_r;
    line_cnt_nxt  = line_cnt_r;
    p1_v_nxt      = 1'b0;
    clr_addr_nxt  = clr_addr_r;
    scan_addr_nxt = scan_addr_r;
    sc_v_nxt      = 1'b0;
    emit_cnt_nxt  = emit_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    emit_load     = 1'b0;
    hist_clear    = 1'b0;
    tbl_we        = 1'b0;
    ctl.pop       = 1'b0;
    ctl.clearing  = (state_r == ST_CLEAR);
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == CNT_AW'(CNT_DEPTH-1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          ctl.pop = 1'b1;
          case (q_data.op)
            OP_LOAD: begin
              tbl_we = (32'(q_data.table_index) < 32'(TABLE_SIZE));
            end
            OP_ADD, OP_REMOVE: begin
              line_addr_nxt = q_data.page_address;
              add_nxt       = (q_data.op == OP_ADD);
              line_cnt_nxt  = '0;
              state_nxt     = ST_LINE;
            end
            default: begin
              scan_addr_nxt = '0;
              hist_clear    = 1'b1;
              state_nxt     = ST_SCAN;
            end
          endcase
        end
      end
      ST_LINE: begin
        p1_v_nxt      = 1'b1;
        line_addr_nxt = line_addr_r + 64'(LINE_BYTES);
        line_cnt_nxt  = line_cnt_r + 1'b1;
        if (line_cnt_r == LC_W'(LINES_PER_PAGE-1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait until the last write has landed
        if (!p1_v_r && !p2_v_r && !sc_v_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        sc_v_nxt      = 1'b1;
        scan_addr_nxt = scan_addr_r + 1'b1;
        if (scan_addr_r == CNT_AW'(CNT_DEPTH-1)) begin
          emit_cnt_nxt = '0;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // one bin per free slot of the output register
        if (!sc_v_r && (!out_valid_r || out_ready)) begin
          emit_load     = 1'b1;
          out_valid_nxt = 1'b1;
          emit_cnt_nxt  = emit_cnt_r + 1'b1;
          if (emit_cnt_r == BIN_W'(BIN_COUNT-1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      sc_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      line_cnt_r  <= '0;
      scan_addr_r <= '0;
      emit_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      p1_v_r      <= p1_v_nxt;
      p2_v_r      <= p1_v_r;
      sc_v_r      <= sc_v_nxt;
      out_valid_r <= out_valid_nxt;
      line_cnt_r  <= line_cnt_nxt;
      scan_addr_r <= scan_addr_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    line_addr_r <= line_addr_nxt;
    add_r       <= add_nxt;
    p1_set_r    <= set0;
    p1_beyond_r <= beyond0;
    p2_addr_r   <= p2_addr_nxt;
    if (hist_clear) begin
      viol_r <= '0;
    end else if (sc_v_r && (cnt_rdata > 16'(way_limit)) && (viol_r != 16'hFFFF)) begin
      viol_r <= viol_r + 16'd1;
    end
    if (emit_load) begin
      out_data_r.bin_index  <= 6'(emit_cnt_r);
      out_data_r.bin_count  <= hist_r[0];
      out_data_r.over_limit <= viol_r;
      out_data_r.last       <= (emit_cnt_r == BIN_W'(BIN_COUNT-1));
    end
  end

  // histogram bins: count while scanning, shift out while emitting
  always_ff @(posedge clk) begin
    for (int b = 0; b < BIN_COUNT; b++) begin
      if (hist_clear) begin
        hist_r[b] <= '0;
      end else if (emit_load) begin
        hist_r[b] <= (b == BIN_COUNT-1) ? 16'd0 : hist_r[(b+1) % BIN_COUNT];
      end else if (sc_v_r && (bin_sel == BIN_W'(b)) && (hist_r[b] != 16'hFFFF)) begin
        hist_r[b] <= hist_r[b] + 16'd1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  csot_ram #(.WIDTH(5), .DEPTH(TABLE_SIZE)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (q_data.table_slice),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  csot_ram #(.WIDTH(16), .DEPTH(CNT_DEPTH)) u_counters (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );
endmodule

>>> src/csot_checker.sv
// Port-level checks of the occupancy tracker result stream, bound to the top.
// Depends on csot_pkg and cache_set_occupancy_tracker_assert.svh.
`include "cache_set_occupancy_tracker_assert.svh"

module csot_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input csot_pkg::out_item_t out_data
);
  import csot_pkg::*;

  localparam logic [5:0] LAST_BIN = 6'(BIN_COUNT_DEF-1);

  logic mid_beat;

  // accepted beat that is not the final bin
  assign mid_beat = out_valid && out_ready && !out_data.last;

  // a stalled result beat holds
  `CSOT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // the final beat carries the last bin
  `CSOT_ASSERT_IMP(a_last_bin, out_valid && out_data.last, out_data.bin_index == LAST_BIN)
  // bins of a snapshot follow back to back in order
  `CSOT_ASSERT_NXT(a_bin_seq, mid_beat, out_valid && out_data.bin_index == $past(out_data.bin_index) + 6'd1)
  // violation count is the same in every beat of a snapshot
  `CSOT_ASSERT_NXT(a_viol_same, mid_beat, out_data.over_limit == $past(out_data.over_limit))
endmodule

bind cache_set_occupancy_tracker csot_checker u_csot_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
